@@ hw/rtl/imu_al_pkg.sv @@
package imu_al_pkg;

   localparam int unsigned SampleW = 16;
   localparam int unsigned RowW    = 48;
   localparam int unsigned AxisN   = 3;
   localparam int unsigned AccW    = 34;
   localparam int unsigned TapW    = 32;
   localparam int unsigned MulW    = 32;
   localparam int unsigned ProdW   = 64;
   localparam int unsigned StepW   = 4;
   localparam int unsigned CsrIdxW = 3;

   // sequencer steps shared by the controller and the lanes
   localparam logic [StepW-1:0] StepRateX  = 4'd0;
   localparam logic [StepW-1:0] StepRateY  = 4'd1;
   localparam logic [StepW-1:0] StepRateZ  = 4'd2;
   localparam logic [StepW-1:0] StepAccX   = 4'd3;
   localparam logic [StepW-1:0] StepAccY   = 4'd4;
   localparam logic [StepW-1:0] StepAccZ   = 4'd5;
   localparam logic [StepW-1:0] StepFiltA0 = 4'd6;
   localparam logic [StepW-1:0] StepFiltA1 = 4'd7;
   localparam logic [StepW-1:0] StepFiltB  = 4'd8;
   localparam logic [StepW-1:0] StepTap    = 4'd10;
   localparam logic [StepW-1:0] StepOut    = 4'd11;

   // register indexes of the configuration port
   localparam logic [CsrIdxW-1:0] CsrMatrixRowX = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrMatrixRowY = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrMatrixRowZ = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrGyroBiasX  = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrGyroBiasY  = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrGyroBiasZ  = 3'd5;

   // filter coefficients, Q2.30
   localparam logic signed [MulW-1:0] CoefA0 = 32'sd2071735500;
   localparam logic signed [MulW-1:0] CoefA1 = -32'sd1000494913;
   localparam logic signed [MulW-1:0] CoefB  = 32'sd2501237;

   localparam logic [RowW-1:0] RowResetX = 48'h0000_0000_4000;
   localparam logic [RowW-1:0] RowResetY = 48'h0000_4000_0000;
   localparam logic [RowW-1:0] RowResetZ = 48'h4000_0000_0000;

   typedef logic signed [SampleW-1:0] s16_type;
   typedef s16_type [AxisN-1:0] vec3_type;

   typedef struct packed {
      s16_type rate_raw_x;
      s16_type rate_raw_y;
      s16_type rate_raw_z;
      s16_type acc_raw_x;
      s16_type acc_raw_y;
      s16_type acc_raw_z;
   } req_payload_type;

   typedef struct packed {
      s16_type rate_out_x;
      s16_type rate_out_y;
      s16_type rate_out_z;
      s16_type acc_rot_x;
      s16_type acc_rot_y;
      s16_type acc_rot_z;
      s16_type acc_smooth_x;
      s16_type acc_smooth_y;
      s16_type acc_smooth_z;
   } rsp_payload_type;

   typedef struct packed {
      logic [StepW-1:0] step;
      logic             tap_en;
      logic             primed;
   } lane_ctl_type;

   typedef struct packed {
      s16_type rate_o;
      s16_type acc_o;
      s16_type smooth_o;
   } lane_res_type;

   // signed Q2.14 coefficient of column col
   function automatic s16_type row_coef(input logic [RowW-1:0] row, input logic [1:0] col);
      s16_type c;
      c = s16_type'(row >> (SampleW * col));
      return c;
   endfunction

   // round half up from Q14, clamp to 16 bits
   function automatic s16_type sat_q14(input logic signed [AccW-1:0] v);
      logic signed [AccW:0]  t;
      logic signed [AccW-14:0] r;
      t = (AccW+1)'(v) + (AccW+1)'(35'sd8192);
      r = $signed(t[AccW:14]);
      if (r > (AccW-13)'(21'sd32767)) return 16'sh7FFF;
      if (r < -(AccW-13)'(21'sd32768)) return 16'sh8000;
      return s16_type'(r[SampleW-1:0]);
   endfunction

   // round half up from Q16, clamp to 16 bits
   function automatic s16_type sat_q16(input logic signed [TapW-1:0] v);
      logic signed [TapW:0]    t;
      logic signed [TapW-16:0] r;
      t = (TapW+1)'(v) + 33'sd32768;
      r = $signed(t[TapW:16]);
      if (r > 17'sd32767) return 16'sh7FFF;
      if (r < -17'sd32768) return 16'sh8000;
      return s16_type'(r[SampleW-1:0]);
   endfunction

   // round half up from Q30, clamp to 32 bits
   function automatic logic signed [TapW-1:0] sat_q30(input logic signed [ProdW-1:0] v);
      logic signed [ProdW-1:0]    t;
      logic signed [ProdW-31:0]   r;
      t = v + 64'sd536870912;
      r = $signed(t[ProdW-1:30]);
      if (r > 34'sd2147483647) return 32'sh7FFF_FFFF;
      if (r < -34'sd2147483648) return 32'sh8000_0000;
      return $signed(r[TapW-1:0]);
   endfunction

endpackage

@@ hw/rtl/imu_al_stream_if.sv @@
interface imu_al_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/imu_al_lane.sv @@
module imu_al_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  imu_al_pkg::lane_ctl_type            ctl,
   input  imu_al_pkg::vec3_type                rate_vec,
   input  imu_al_pkg::vec3_type                acc_vec,
   input  logic [imu_al_pkg::RowW-1:0]         row,
   input  imu_al_pkg::s16_type                 bias,
   output imu_al_pkg::lane_res_type            res
);
   import imu_al_pkg::*;

   logic signed [MulW-1:0]  mul_a;
   logic signed [MulW-1:0]  mul_b;
   logic signed [ProdW-1:0] prod_ff;
   logic [StepW-1:0]        tag_ff;
   logic signed [AccW-1:0]  gyro_sum_ff;
   logic signed [AccW-1:0]  acc_sum_ff;
   logic signed [ProdW-1:0] filt_sum_ff;
   s16_type                 acc_o_ff;
   logic signed [TapW-1:0]  tap_last_ff;
   logic signed [TapW-1:0]  tap_prev_ff;
   logic signed [TapW-1:0]  filt_x;
   logic signed [AccW-1:0]  prod_narrow;
   logic signed [AccW-1:0]  bias_q14;

   assign filt_x      = $signed({acc_o_ff, 16'h0000});
   assign prod_narrow = $signed(prod_ff[AccW-1:0]);
   assign bias_q14    = $signed({{(AccW-30){bias[SampleW-1]}}, bias, 14'h0000});

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctl.step)
         StepRateX: begin
            mul_a = MulW'(rate_vec[0]);
            mul_b = MulW'(row_coef(row, 2'd0));
         end
         StepRateY: begin
            mul_a = MulW'(rate_vec[1]);
            mul_b = MulW'(row_coef(row, 2'd1));
         end
         StepRateZ: begin
            mul_a = MulW'(rate_vec[2]);
            mul_b = MulW'(row_coef(row, 2'd2));
         end
         StepAccX: begin
            mul_a = MulW'(acc_vec[0]);
            mul_b = MulW'(row_coef(row, 2'd0));
         end
         StepAccY: begin
            mul_a = MulW'(acc_vec[1]);
            mul_b = MulW'(row_coef(row, 2'd1));
         end
         StepAccZ: begin
            mul_a = MulW'(acc_vec[2]);
            mul_b = MulW'(row_coef(row, 2'd2));
         end
         StepFiltA0: begin
            mul_a = CoefA0;
            mul_b = tap_last_ff;
         end
         StepFiltA1: begin
            mul_a = CoefA1;
            mul_b = tap_prev_ff;
         end
         StepFiltB: begin
            mul_a = CoefB;
            mul_b = filt_x;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff  <= mul_a * mul_b;
      tag_ff   <= ctl.step;
      acc_o_ff <= sat_q14(acc_sum_ff);
      case (tag_ff) inside
         StepRateX:              gyro_sum_ff <= prod_narrow - bias_q14;
         StepRateY, StepRateZ:   gyro_sum_ff <= gyro_sum_ff + prod_narrow;
         StepAccX:               acc_sum_ff  <= prod_narrow;
         StepAccY, StepAccZ:     acc_sum_ff  <= acc_sum_ff + prod_narrow;
         StepFiltA0:             filt_sum_ff <= prod_ff;
         StepFiltA1, StepFiltB:  filt_sum_ff <= filt_sum_ff + prod_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_last_ff <= '0;
         tap_prev_ff <= '0;
      end else if (ctl.tap_en) begin
         if (!ctl.primed) begin
            tap_last_ff <= filt_x;
            tap_prev_ff <= filt_x;
         end else begin
            tap_prev_ff <= tap_last_ff;
            tap_last_ff <= sat_q30(filt_sum_ff);
         end
      end
   end

   assign res.rate_o   = sat_q14(gyro_sum_ff);
   assign res.acc_o    = acc_o_ff;
   assign res.smooth_o = sat_q16(tap_last_ff);

endmodule

@@ hw/rtl/imu_align_and_accel_lowpass.sv @@
// channel  dir  handshake         payload
// req_if   in   valid/ready       raw gyro and accel, six signed 16-bit axes
// rsp_if   out  valid/ready       rotated rates, rotated accel, filtered accel
// csr      in   csr_we only       csr_index selects one of six registers
//
// Between accept and the result register, each axis lane runs nine products in
// turn through its own 32x32 multiplier, then rounds and updates its filter taps.
// A new item is accepted the cycle after the result loads, so the block takes no
// new item while the last one is still in the lanes or waiting to load.
// Reset is synchronous; it restores the identity matrix, zero bias and unprimed taps.
// A stalled rsp_if holds the finished result and the lanes until it is taken.
module imu_align_and_accel_lowpass (
   input  logic                                   clock,
   input  logic                                   reset,
   imu_al_stream_if.sink                          req_if,
   imu_al_stream_if.source                        rsp_if,
   input  logic                                   csr_we,
   input  logic [imu_al_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [imu_al_pkg::RowW-1:0]            csr_wdata
);
   import imu_al_pkg::*;

   logic [RowW-1:0]     matrix_row_ff [AxisN];
   s16_type             bias_ff [AxisN];
   req_payload_type     req_hold_ff;
   rsp_payload_type     rsp_data_ff;
   logic                rsp_valid_ff;
   logic                busy_ff;
   logic                primed_ff;
   logic [StepW-1:0]    step_ff;
   logic                req_xfer;
   logic                rsp_xfer;
   logic                rsp_load;
   lane_ctl_type        lane_ctl;
   vec3_type            rate_vec;
   vec3_type            acc_vec;
   lane_res_type        lane_res [AxisN];

   assign req_if.ready = !busy_ff;
   assign req_xfer     = req_if.valid && !busy_ff;
   assign rsp_xfer     = rsp_valid_ff && rsp_if.ready;
   assign rsp_load     = busy_ff && (step_ff == StepOut) && (!rsp_valid_ff || rsp_if.ready);

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   assign rate_vec[0] = req_hold_ff.rate_raw_x;
   assign rate_vec[1] = req_hold_ff.rate_raw_y;
   assign rate_vec[2] = req_hold_ff.rate_raw_z;
   assign acc_vec[0]  = req_hold_ff.acc_raw_x;
   assign acc_vec[1]  = req_hold_ff.acc_raw_y;
   assign acc_vec[2]  = req_hold_ff.acc_raw_z;

   assign lane_ctl.step   = step_ff;
   assign lane_ctl.tap_en = busy_ff && (step_ff == StepTap);
   assign lane_ctl.primed = primed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_row_ff[0] <= RowResetX;
         matrix_row_ff[1] <= RowResetY;
         matrix_row_ff[2] <= RowResetZ;
         bias_ff[0]       <= '0;
         bias_ff[1]       <= '0;
         bias_ff[2]       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrMatrixRowX: matrix_row_ff[0] <= csr_wdata;
            CsrMatrixRowY: matrix_row_ff[1] <= csr_wdata;
            CsrMatrixRowZ: matrix_row_ff[2] <= csr_wdata;
            CsrGyroBiasX:  bias_ff[0] <= s16_type'(csr_wdata[SampleW-1:0]);
            CsrGyroBiasY:  bias_ff[1] <= s16_type'(csr_wdata[SampleW-1:0]);
            CsrGyroBiasZ:  bias_ff[2] <= s16_type'(csr_wdata[SampleW-1:0]);
            default: ;
         endcase
      end
   end

   // sequencer: advance one step per cycle, hold at the last step until the
   // result register is free
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         step_ff   <= StepRateX;
         primed_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            busy_ff <= 1'b1;
            step_ff <= StepRateX;
         end else if (rsp_load) begin
            busy_ff <= 1'b0;
            step_ff <= StepRateX;
         end else if (busy_ff && step_ff != StepOut) begin
            step_ff <= step_ff + 1'b1;
         end
         if (lane_ctl.tap_en) primed_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) req_hold_ff <= req_if.data;
   end

   for (genvar g = 0; g < AxisN; g++) begin : g_lane
      imu_al_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .rate_vec (rate_vec),
         .acc_vec  (acc_vec),
         .row      (matrix_row_ff[g]),
         .bias     (bias_ff[g]),
         .res      (lane_res[g])
      );
   end

   // merge the three lanes into one result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.rate_out_x   <= lane_res[0].rate_o;
         rsp_data_ff.rate_out_y   <= lane_res[1].rate_o;
         rsp_data_ff.rate_out_z   <= lane_res[2].rate_o;
         rsp_data_ff.acc_rot_x    <= lane_res[0].acc_o;
         rsp_data_ff.acc_rot_y    <= lane_res[1].acc_o;
         rsp_data_ff.acc_rot_z    <= lane_res[2].acc_o;
         rsp_data_ff.acc_smooth_x <= lane_res[0].smooth_o;
         rsp_data_ff.acc_smooth_y <= lane_res[1].smooth_o;
         rsp_data_ff.acc_smooth_z <= lane_res[2].smooth_o;
      end
   end

   a_accept_at_start: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |-> step_ff == StepRateX)
      else $error("input accepted with sequencer mid-item");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= StepOut)
      else $error("sequencer step out of range");

   a_primed_sticky: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("filter lost its primed state");

   a_tap_primes: assert property (@(posedge clock) disable iff (reset)
      lane_ctl.tap_en |=> primed_ff && $past(step_ff) == StepTap)
      else $error("tap update did not prime the filter");

endmodule
